@@ design/lkrt_pkg.sv @@
package lkrt_pkg;

    localparam int FIELD_W = 64;
    localparam int STAMP_W = 32;
    localparam int USES_W  = 16;
    localparam int SLOT_W  = 5;
    localparam int OCC_W   = 6;
    localparam int RANK_W  = 5;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [USES_W-1:0]  USES_MAX  = '1;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_TOUCH  = 3'd4,
        CMD_RANK   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_SCAN  = 2'd1,
        RES_FETCH = 2'd2
    } t_res;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan_start;
        logic scan_issue;
        logic resolve;
        logic fetch;
        logic update;
    } t_ctl;

    typedef struct packed {
        t_res dec_res;
        t_res scan_res;
        logic addr_last;
    } t_st;

endpackage

@@ design/lkrt_ctrl.sv @@
module lkrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_strobe,
    output lkrt_pkg::t_ctl o_ctl,
    input  lkrt_pkg::t_st  i_st
);
    import lkrt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_SCAN    = 8'b0000_0100,
        S_DRAIN   = 8'b0000_1000,
        S_RESOLVE = 8'b0001_0000,
        S_FETCH   = 8'b0010_0000,
        S_UPDATE  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.decode = 1'b1;
                case (i_st.dec_res)
                    RES_SCAN: begin
                        o_ctl.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    RES_FETCH: n_state = S_FETCH;
                    default:   n_state = S_RESP;
                endcase
            end
            S_SCAN: begin
                o_ctl.scan_issue = 1'b1;
                if (i_st.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_RESOLVE;
            S_RESOLVE: begin
                o_ctl.resolve = 1'b1;
                case (i_st.scan_res)
                    RES_SCAN: begin
                        o_ctl.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    RES_FETCH: n_state = S_FETCH;
                    default:   n_state = S_RESP;
                endcase
            end
            S_FETCH: begin
                o_ctl.fetch = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_ctl.update = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_RESP);

endmodule

@@ design/lkrt_dp.sv @@
module lkrt_dp #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lkrt_pkg::t_ctl                 i_ctl,
    output lkrt_pkg::t_st                  o_st,
    input  logic [2:0]                     i_cmd,
    input  logic [lkrt_pkg::FIELD_W-1:0]   i_key,
    input  logic [lkrt_pkg::FIELD_W-1:0]   i_value,
    input  logic                           i_has_value,
    input  logic [lkrt_pkg::RANK_W-1:0]    i_rank,
    input  logic [lkrt_pkg::SLOT_W-1:0]    i_slot_in,
    output logic [1:0]                     o_status,
    output logic [lkrt_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [lkrt_pkg::FIELD_W-1:0]   o_key_out,
    output logic [lkrt_pkg::FIELD_W-1:0]   o_value_out,
    output logic [lkrt_pkg::USES_W-1:0]    o_use_count,
    output logic [lkrt_pkg::OCC_W-1:0]     o_occupied,
    output logic                           o_evicted,
    output logic                           o_was_known
);
    import lkrt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = 8 * KEY_BYTES;
    localparam int VW = 8 * VALUE_BYTES;
    localparam int OW = STAMP_W + IW;

    logic [KW-1:0]      r_mem_key   [TABLE_DEPTH];
    logic [VW-1:0]      r_mem_val   [TABLE_DEPTH];
    logic [STAMP_W-1:0] r_mem_stamp [TABLE_DEPTH];
    logic [USES_W-1:0]  r_mem_uses  [TABLE_DEPTH];

    t_cmd               r_cmd;
    logic [KW-1:0]      r_key;
    logic [VW-1:0]      r_val;
    logic               r_hv;
    logic [RANK_W-1:0]  r_rank;
    logic [SLOT_W-1:0]  r_slot_in;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CW-1:0]          r_total;
    logic [STAMP_W-1:0]     r_next_stamp;

    logic [IW-1:0]      r_addr;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic [IW-1:0]      r_sel;
    logic [KW-1:0]      r_rd_key;
    logic [VW-1:0]      r_rd_val;
    logic [STAMP_W-1:0] r_rd_stamp;
    logic [USES_W-1:0]  r_rd_uses;

    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic               r_free;
    logic [IW-1:0]      r_free_idx;
    logic               r_min_f;
    logic [IW-1:0]      r_min_idx;
    logic [STAMP_W-1:0] r_min_stamp;
    logic               r_best_f;
    logic [OW-1:0]      r_best;
    logic [OW-1:0]      r_bound;
    logic               r_bound_inf;
    logic [RANK_W-1:0]  r_pass;

    t_status            r_o_status;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [FIELD_W-1:0] r_o_key;
    logic [FIELD_W-1:0] r_o_val;
    logic [USES_W-1:0]  r_o_uses;
    logic [OCC_W-1:0]   r_o_occ;
    logic               r_o_ev;
    logic               r_o_known;

    logic               key_zero;
    logic               slot_bad;
    logic [IW-1:0]      slot_idx;
    logic               slot_empty;
    logic               rd_v;
    logic [OW-1:0]      rd_ord;
    logic [IW-1:0]      rd_addr;
    logic [STAMP_W-1:0] stamp_inc;
    logic [USES_W-1:0]  uses_inc;
    logic               is_new;
    logic               is_touch;
    logic               is_write_val;
    logic [KW-1:0]      w_key;
    logic [VW-1:0]      w_val;
    logic [USES_W-1:0]  w_uses;
    logic [CW-1:0]      w_total;
    t_res               dec_res;
    t_res               scan_res;

    assign key_zero   = (r_key == '0);
    assign slot_bad   = (32'(r_slot_in) >= TABLE_DEPTH);
    assign slot_idx   = IW'(r_slot_in);
    assign slot_empty = !r_valid[slot_idx];
    assign rd_v       = r_valid[r_rd_idx];
    assign rd_ord     = {r_rd_stamp, ~r_rd_idx};
    assign rd_addr    = i_ctl.fetch ? r_sel : r_addr;
    assign stamp_inc  = (r_next_stamp == STAMP_MAX) ? r_next_stamp : r_next_stamp + 1'b1;
    assign uses_inc   = (r_rd_uses == USES_MAX) ? r_rd_uses : r_rd_uses + 1'b1;

    assign is_new       = (r_cmd == CMD_ADD) && !r_hit;
    assign is_touch     = (r_cmd == CMD_ADD) || (r_cmd == CMD_TOUCH);
    assign is_write_val = (r_cmd == CMD_ADD) || (r_cmd == CMD_SET);

    always_comb begin
        w_key = is_new ? r_key : r_rd_key;
        if (is_write_val && r_hv) begin
            w_val = r_val;
        end else if (is_new) begin
            w_val = '0;
        end else begin
            w_val = r_rd_val;
        end
        if (is_new) begin
            w_uses = USES_W'(1);
        end else if (is_touch) begin
            w_uses = uses_inc;
        end else begin
            w_uses = r_rd_uses;
        end
        if (is_new && r_free) begin
            w_total = r_total + 1'b1;
        end else if ((r_cmd == CMD_REMOVE) && (r_total != '0)) begin
            w_total = r_total - 1'b1;
        end else begin
            w_total = r_total;
        end
    end

    always_comb begin
        case (r_cmd)
            CMD_ADD, CMD_SET, CMD_REMOVE, CMD_FIND: dec_res = key_zero ? RES_DONE : RES_SCAN;
            CMD_TOUCH: dec_res = (slot_bad || slot_empty) ? RES_DONE : RES_FETCH;
            CMD_RANK:  dec_res = RES_SCAN;
            default:   dec_res = RES_DONE;
        endcase
        case (r_cmd)
            CMD_ADD: scan_res = RES_FETCH;
            CMD_SET, CMD_REMOVE, CMD_FIND: scan_res = r_hit ? RES_FETCH : RES_DONE;
            CMD_RANK: begin
                if (!r_best_f) begin
                    scan_res = RES_DONE;
                end else if (r_pass == r_rank) begin
                    scan_res = RES_FETCH;
                end else begin
                    scan_res = RES_SCAN;
                end
            end
            default: scan_res = RES_DONE;
        endcase
    end

    assign o_st.dec_res   = dec_res;
    assign o_st.scan_res  = scan_res;
    assign o_st.addr_last = (r_addr == IW'(TABLE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            if (is_touch) begin
                r_mem_stamp[r_sel] <= r_next_stamp;
                r_mem_uses[r_sel]  <= w_uses;
            end
            if (is_write_val) begin
                r_mem_val[r_sel] <= w_val;
            end
            if (is_new) begin
                r_mem_key[r_sel] <= w_key;
            end
        end
        r_rd_key   <= r_mem_key[rd_addr];
        r_rd_val   <= r_mem_val[rd_addr];
        r_rd_stamp <= r_mem_stamp[rd_addr];
        r_rd_uses  <= r_mem_uses[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_total      <= '0;
            r_next_stamp <= STAMP_W'(1);
            r_rd_vld     <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.scan_issue;
            if (i_ctl.decode && (r_cmd == CMD_CLEAR)) begin
                r_valid      <= '0;
                r_total      <= '0;
                r_next_stamp <= STAMP_W'(1);
            end
            if (i_ctl.update) begin
                if (is_touch) begin
                    r_next_stamp <= stamp_inc;
                end
                if (is_new) begin
                    r_valid[r_sel] <= 1'b1;
                end
                if (r_cmd == CMD_REMOVE) begin
                    r_valid[r_sel] <= 1'b0;
                end
                r_total <= w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_key     <= i_key[KW-1:0];
            r_val     <= i_value[VW-1:0];
            r_hv      <= i_has_value;
            r_rank    <= i_rank;
            r_slot_in <= i_slot_in;
        end
        r_rd_idx <= r_addr;

        if (i_ctl.scan_start) begin
            r_addr   <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_min_f  <= 1'b0;
            r_best_f <= 1'b0;
        end else begin
            if (i_ctl.scan_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_rd_vld) begin
                if (rd_v && (r_rd_key == r_key) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (!rd_v && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (rd_v && (!r_min_f || (r_rd_stamp < r_min_stamp))) begin
                    r_min_f     <= 1'b1;
                    r_min_idx   <= r_rd_idx;
                    r_min_stamp <= r_rd_stamp;
                end
                if (rd_v && (r_bound_inf || (rd_ord < r_bound))
                        && (!r_best_f || (rd_ord > r_best))) begin
                    r_best_f <= 1'b1;
                    r_best   <= rd_ord;
                end
            end
        end

        if (i_ctl.decode) begin
            r_bound_inf <= 1'b1;
            r_pass      <= '0;
            r_sel       <= slot_idx;
            if ((r_cmd == CMD_ADD || r_cmd == CMD_SET || r_cmd == CMD_REMOVE
                    || r_cmd == CMD_FIND) && key_zero) begin
                r_o_status <= ST_BAD;
            end else if ((r_cmd == CMD_TOUCH) && slot_bad) begin
                r_o_status <= ST_BAD;
            end else if ((r_cmd == CMD_TOUCH) && slot_empty) begin
                r_o_status <= ST_MISS;
            end else begin
                r_o_status <= ST_OK;
            end
            r_o_slot  <= '0;
            r_o_key   <= '0;
            r_o_val   <= '0;
            r_o_uses  <= '0;
            r_o_occ   <= (r_cmd == CMD_CLEAR) ? '0 : OCC_W'(r_total);
            r_o_ev    <= 1'b0;
            r_o_known <= 1'b0;
        end

        if (i_ctl.resolve) begin
            case (scan_res)
                RES_FETCH: begin
                    if (r_cmd == CMD_RANK) begin
                        r_sel <= ~r_best[IW-1:0];
                    end else if (r_cmd == CMD_ADD) begin
                        if (r_hit) begin
                            r_sel <= r_hit_idx;
                        end else if (r_free) begin
                            r_sel <= r_free_idx;
                        end else begin
                            r_sel <= r_min_idx;
                        end
                    end else begin
                        r_sel <= r_hit_idx;
                    end
                end
                RES_SCAN: begin
                    r_bound     <= r_best;
                    r_bound_inf <= 1'b0;
                    r_pass      <= r_pass + 1'b1;
                end
                default: begin
                    r_o_status <= ST_MISS;
                end
            endcase
        end

        if (i_ctl.update) begin
            r_o_status <= ST_OK;
            r_o_slot   <= SLOT_W'(r_sel);
            r_o_key    <= FIELD_W'(w_key);
            r_o_val    <= FIELD_W'(w_val);
            r_o_uses   <= w_uses;
            r_o_occ    <= OCC_W'(w_total);
            r_o_ev     <= is_new && !r_free;
            r_o_known  <= (r_cmd == CMD_ADD) && r_hit;
        end
    end

    assign o_status    = r_o_status;
    assign o_slot_out  = r_o_slot;
    assign o_key_out   = r_o_key;
    assign o_value_out = r_o_val;
    assign o_use_count = r_o_uses;
    assign o_occupied  = r_o_occ;
    assign o_evicted   = r_o_ev;
    assign o_was_known = r_o_known;

endmodule

@@ design/lru_keyed_record_table.sv @@
// Add, set, remove and find scan the whole table (decode, scan, drain, resolve), then fetch and
// update the record they reach before the result strobe; set, remove and find skip the update
// on a miss. touch_slot skips the scan, and clear, rejected and undefined commands respond right
// after decode. A rank command that finds its record runs one full table scan per rank first.
// A new transaction is taken only after the previous one, as busy stays high until its strobe.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset is synchronous and active low; it empties the table and sets the stamp counter to one.
module lru_keyed_record_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BYTES   = 8,
    parameter int VALUE_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_cmd,
    input  logic [lkrt_pkg::FIELD_W-1:0] i_key,
    input  logic [lkrt_pkg::FIELD_W-1:0] i_value,
    input  logic                         i_has_value,
    input  logic [lkrt_pkg::RANK_W-1:0]  i_rank,
    input  logic [lkrt_pkg::SLOT_W-1:0]  i_slot_in,
    output logic                         o_strobe,
    output logic [1:0]                   o_status,
    output logic [lkrt_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [lkrt_pkg::FIELD_W-1:0] o_key_out,
    output logic [lkrt_pkg::FIELD_W-1:0] o_value_out,
    output logic [lkrt_pkg::USES_W-1:0]  o_use_count,
    output logic [lkrt_pkg::OCC_W-1:0]   o_occupied,
    output logic                         o_evicted,
    output logic                         o_was_known
);
    import lkrt_pkg::*;

    t_ctl ctl;
    t_st  st;

    lkrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_ctl    (ctl),
        .i_st     (st)
    );

    lkrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_st        (st),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_value     (i_value),
        .i_has_value (i_has_value),
        .i_rank      (i_rank),
        .i_slot_in   (i_slot_in),
        .o_status    (o_status),
        .o_slot_out  (o_slot_out),
        .o_key_out   (o_key_out),
        .o_value_out (o_value_out),
        .o_use_count (o_use_count),
        .o_occupied  (o_occupied),
        .o_evicted   (o_evicted),
        .o_was_known (o_was_known)
    );

endmodule

@@ design/lkrt_chk.sv @@
module lkrt_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic [1:0]                   o_status,
    input logic [lkrt_pkg::SLOT_W-1:0]  o_slot_out,
    input logic [lkrt_pkg::FIELD_W-1:0] o_key_out,
    input logic [lkrt_pkg::USES_W-1:0]  o_use_count,
    input logic                         o_evicted,
    input logic                         o_was_known
);
    import lkrt_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe && !busy)
        else $error("result strobe not followed by an idle cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |->
            (o_slot_out == '0) && (o_key_out == '0) && (o_use_count == '0)
            && !o_evicted && !o_was_known)
        else $error("failed transaction reports record fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status != 2'd3) && !(o_evicted && o_was_known))
        else $error("inconsistent result flags");

endmodule

bind lru_keyed_record_table lkrt_chk u_lkrt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_status    (o_status),
    .o_slot_out  (o_slot_out),
    .o_key_out   (o_key_out),
    .o_use_count (o_use_count),
    .o_evicted   (o_evicted),
    .o_was_known (o_was_known)
);

@@ verif/lru_keyed_record_table_checker.sv @@
`timescale 1ns / 100ps

module lru_keyed_record_table_checker
    import lkrt_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic [FIELD_W-1:0] i_key,
    input  logic [FIELD_W-1:0] i_value,
    input  logic               i_has_value,
    input  logic [RANK_W-1:0]  i_rank,
    input  logic [SLOT_W-1:0]  i_slot_in,
    input  logic               o_strobe,
    input  logic [1:0]         o_status,
    input  logic [SLOT_W-1:0]  o_slot_out,
    input  logic [FIELD_W-1:0] o_key_out,
    input  logic [FIELD_W-1:0] o_value_out,
    input  logic [USES_W-1:0]  o_use_count,
    input  logic [OCC_W-1:0]   o_occupied,
    input  logic               o_evicted,
    input  logic               o_was_known,
    output int                 failures,
    output int                 pending,
    output int                 results_seen,
    output int                 evictions_seen
);

    typedef struct {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] value;
        logic [USES_W-1:0]  uses;
        logic [OCC_W-1:0]   occupied;
        logic               evicted;
        logic               known;
    } t_record_result;

    logic               rec_valid [DEPTH];
    logic [FIELD_W-1:0] rec_key   [DEPTH];
    logic [FIELD_W-1:0] rec_value [DEPTH];
    logic [STAMP_W-1:0] rec_stamp [DEPTH];
    logic [USES_W-1:0]  rec_uses  [DEPTH];
    logic [STAMP_W-1:0] stamp_next;
    int                 live_count;

    t_record_result expected_results[$];

    function automatic logic [STAMP_W-1:0] claim_stamp();
        logic [STAMP_W-1:0] s;
        s = stamp_next;
        if (stamp_next != STAMP_MAX) stamp_next++;
        return s;
    endfunction

    function automatic int find_slot(logic [FIELD_W-1:0] k);
        for (int i = 0; i < DEPTH; i++) begin
            if (rec_valid[i] && rec_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic t_record_result report(t_status st, int s, logic ev, logic kn);
        t_record_result r;
        r = '{default: '0};
        r.status = st;
        if (st == ST_OK && s >= 0) begin
            r.slot = s[SLOT_W-1:0];
            r.key = rec_key[s];
            r.value = rec_value[s];
            r.uses = rec_uses[s];
        end
        r.occupied = live_count[OCC_W-1:0];
        r.evicted = ev;
        r.known = kn;
        return r;
    endfunction

    function automatic t_record_result predict_command(logic [2:0] cmd,
        logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] v, logic hv,
        logic [RANK_W-1:0] rank, logic [SLOT_W-1:0] sl);
        int s;
        int ahead;
        logic ev;
        logic [STAMP_W-1:0] oldest;
        t_record_result r;
        s = -1;
        ev = 1'b0;
        if (cmd <= CMD_FIND && k == '0) return report(ST_BAD, -1, 1'b0, 1'b0);
        case (cmd)
            CMD_ADD: begin
                s = find_slot(k);
                if (s >= 0) begin
                    rec_stamp[s] = claim_stamp();
                    if (rec_uses[s] != USES_MAX) rec_uses[s]++;
                    if (hv) rec_value[s] = v;
                    return report(ST_OK, s, 1'b0, 1'b1);
                end
                for (int i = 0; i < DEPTH && s < 0; i++) begin
                    if (!rec_valid[i]) s = i;
                end
                if (s < 0) begin
                    oldest = '0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (rec_valid[i] && (s < 0 || rec_stamp[i] < oldest)) begin
                            oldest = rec_stamp[i];
                            s = i;
                        end
                    end
                    ev = 1'b1;
                end else begin
                    live_count++;
                end
                rec_valid[s] = 1'b1;
                rec_key[s] = k;
                rec_value[s] = hv ? v : '0;
                rec_stamp[s] = claim_stamp();
                rec_uses[s] = USES_W'(1);
                return report(ST_OK, s, ev, 1'b0);
            end
            CMD_SET: begin
                s = find_slot(k);
                if (s < 0) return report(ST_MISS, -1, 1'b0, 1'b0);
                if (hv) rec_value[s] = v;
                return report(ST_OK, s, 1'b0, 1'b0);
            end
            CMD_REMOVE: begin
                s = find_slot(k);
                if (s < 0) return report(ST_MISS, -1, 1'b0, 1'b0);
                if (live_count > 0) live_count--;
                r = report(ST_OK, s, 1'b0, 1'b0);
                rec_valid[s] = 1'b0;
                return r;
            end
            CMD_FIND: begin
                s = find_slot(k);
                return report(s < 0 ? ST_MISS : ST_OK, s, 1'b0, 1'b0);
            end
            CMD_TOUCH: begin
                if (sl >= DEPTH) return report(ST_BAD, -1, 1'b0, 1'b0);
                if (!rec_valid[sl]) return report(ST_MISS, -1, 1'b0, 1'b0);
                rec_stamp[sl] = claim_stamp();
                if (rec_uses[sl] != USES_MAX) rec_uses[sl]++;
                return report(ST_OK, int'(sl), 1'b0, 1'b0);
            end
            CMD_RANK: begin
                for (int i = 0; i < DEPTH && s < 0; i++) begin
                    if (rec_valid[i]) begin
                        ahead = 0;
                        for (int j = 0; j < DEPTH; j++) begin
                            if (rec_valid[j] && (rec_stamp[j] > rec_stamp[i] ||
                                (rec_stamp[j] == rec_stamp[i] && j < i))) ahead++;
                        end
                        if (ahead == int'(rank)) s = i;
                    end
                end
                return report(s < 0 ? ST_MISS : ST_OK, s, 1'b0, 1'b0);
            end
            CMD_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) rec_valid[i] = 1'b0;
                live_count = 0;
                stamp_next = STAMP_W'(1);
                return report(ST_OK, -1, 1'b0, 1'b0);
            end
            default: return report(ST_OK, -1, 1'b0, 1'b0);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_record_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) rec_valid[i] <= 1'b0;
            stamp_next <= STAMP_W'(1);
            live_count <= 0;
            failures = 0;
            results_seen = 0;
            evictions_seen = 0;
            expected_results.delete();
        end else begin
            if (o_strobe) begin
                results_seen++;
                if (o_evicted) evictions_seen++;
                if (expected_results.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    failures++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status);
                        failures++;
                    end
                    if (o_slot_out !== e.slot) begin
                        $error("slot_out: expected %0d, got %0d", e.slot, o_slot_out);
                        failures++;
                    end
                    if (o_key_out !== e.key) begin
                        $error("key_out: expected %h, got %h", e.key, o_key_out);
                        failures++;
                    end
                    if (o_value_out !== e.value) begin
                        $error("value_out: expected %h, got %h", e.value, o_value_out);
                        failures++;
                    end
                    if (o_use_count !== e.uses) begin
                        $error("use_count: expected %0d, got %0d", e.uses, o_use_count);
                        failures++;
                    end
                    if (o_occupied !== e.occupied) begin
                        $error("occupied: expected %0d, got %0d", e.occupied, o_occupied);
                        failures++;
                    end
                    if (o_evicted !== e.evicted) begin
                        $error("evicted: expected %0d, got %0d", e.evicted, o_evicted);
                        failures++;
                    end
                    if (o_was_known !== e.known) begin
                        $error("was_known: expected %0d, got %0d", e.known, o_was_known);
                        failures++;
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(predict_command(i_cmd, i_key, i_value,
                    i_has_value, i_rank, i_slot_in));
            end
        end
        pending <= expected_results.size();
    end

endmodule

@@ verif/lru_keyed_record_table_tb.sv @@
`timescale 1ns / 100ps

module lru_keyed_record_table_tb;
    import lkrt_pkg::*;

    localparam int DEPTH = 32;
    localparam int RANDOM_ITEMS = 1300;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_cmd;
    logic [FIELD_W-1:0] i_key;
    logic [FIELD_W-1:0] i_value;
    logic               i_has_value;
    logic [RANK_W-1:0]  i_rank;
    logic [SLOT_W-1:0]  i_slot_in;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [FIELD_W-1:0] o_key_out;
    logic [FIELD_W-1:0] o_value_out;
    logic [USES_W-1:0]  o_use_count;
    logic [OCC_W-1:0]   o_occupied;
    logic               o_evicted;
    logic               o_was_known;
    int                 failures;
    int                 pending;
    int                 results_seen;
    int                 evictions_seen;

    logic [FIELD_W-1:0] key_pool [48];
    int                 idle_pct;

    lru_keyed_record_table #(.TABLE_DEPTH(DEPTH)) dut (.*);

    lru_keyed_record_table_checker #(.DEPTH(DEPTH)) checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic issue(logic [2:0] cmd, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] v,
        logic hv, logic [RANK_W-1:0] rank, logic [SLOT_W-1:0] sl);
        start <= 1'b1;
        i_cmd <= cmd;
        i_key <= k;
        i_value <= v;
        i_has_value <= hv;
        i_rank <= rank;
        i_slot_in <= sl;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [FIELD_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 9) return rand_word();
        return key_pool[$urandom_range(47)];
    endfunction

    task automatic random_command();
        int r;
        logic [2:0] cmd;
        logic [RANK_W-1:0] rank;
        r = $urandom_range(99);
        if (r < 38) cmd = CMD_ADD;
        else if (r < 48) cmd = CMD_SET;
        else if (r < 58) cmd = CMD_REMOVE;
        else if (r < 73) cmd = CMD_FIND;
        else if (r < 85) cmd = CMD_TOUCH;
        else if (r < 95) cmd = CMD_RANK;
        else if (r < 97) cmd = CMD_CLEAR;
        else cmd = 3'd7;
        rank = ($urandom_range(4) == 0) ? RANK_W'($urandom_range(31))
                                        : RANK_W'($urandom_range(7));
        issue(cmd, pick_key(), rand_word(), 1'($urandom()), rank,
              SLOT_W'($urandom_range(31)));
    endtask

    initial begin
        start = 1'b0;
        i_cmd = CMD_CLEAR;
        i_key = '0;
        i_value = '0;
        i_has_value = 1'b0;
        i_rank = '0;
        i_slot_in = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        for (int i = 0; i < 48; i++) key_pool[i] = rand_word();
        key_pool[0] = '1;
        key_pool[1] = 64'd1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(CMD_RANK, '0, '0, 1'b0, '0, '0);
        issue(CMD_TOUCH, '0, '0, 1'b0, '0, 5'd31);
        issue(CMD_ADD, '1, '1, 1'b1, '0, '0);
        issue(CMD_ADD, 64'd1, '1, 1'b0, '0, '0);
        issue(CMD_ADD, '1, 64'h1234, 1'b0, '0, '0);
        issue(CMD_ADD, '1, '0, 1'b1, '0, '0);
        issue(CMD_ADD, '0, '1, 1'b1, '0, '0);
        issue(CMD_SET, '0, '1, 1'b1, '0, '0);
        issue(CMD_REMOVE, '0, '0, 1'b0, '0, '0);
        issue(CMD_FIND, '0, '0, 1'b0, '0, '0);
        issue(CMD_SET, 64'd1, 64'hA5A5_5A5A_F00F_0FF0, 1'b1, '0, '0);
        issue(CMD_SET, 64'd1, '1, 1'b0, '0, '0);
        issue(CMD_FIND, 64'd1, '0, 1'b0, '0, '0);
        issue(CMD_FIND, 64'd2, '0, 1'b0, '0, '0);
        issue(CMD_TOUCH, '0, '0, 1'b0, '0, 5'd1);
        issue(CMD_TOUCH, '0, '0, 1'b0, '0, 5'd2);
        issue(CMD_RANK, '0, '0, 1'b0, 5'd0, '0);
        issue(CMD_RANK, '0, '0, 1'b0, 5'd1, '0);
        issue(CMD_RANK, '0, '0, 1'b0, 5'd31, '0);
        issue(CMD_REMOVE, '1, '0, 1'b0, '0, '0);
        issue(CMD_REMOVE, '1, '0, 1'b0, '0, '0);
        issue(3'd7, '1, '1, 1'b1, 5'd31, 5'd31);
        issue(CMD_CLEAR, '0, '0, 1'b0, '0, '0);
        issue(CMD_FIND, 64'd1, '0, 1'b0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (n / 260)
                0: idle_pct = 0;
                1: idle_pct = 56;
                2: idle_pct = 17;
                3: idle_pct = 56;
                default: idle_pct = 0;
            endcase
            if (n == 650) drain();
            random_command();
        end

        drain();
        repeat (1200) @(posedge i_clk);
        $display("Covered %0d results (%0d with eviction) over all seven commands,",
                 results_seen, evictions_seen);
        $display("including zero keys, misses, table overflow, rank scans and clears.");
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ lru_keyed_record_table.f @@
design/lkrt_pkg.sv
design/lkrt_ctrl.sv
design/lkrt_dp.sv
design/lru_keyed_record_table.sv
design/lkrt_chk.sv
verif/lru_keyed_record_table_checker.sv
verif/lru_keyed_record_table_tb.sv
